// File: hw/rtl/vad_utterance_segmenter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the VAD utterance segmenter
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef VAD_UTTERANCE_SEGMENTER_CORE_DEFINES_SVH
`define VAD_UTTERANCE_SEGMENTER_CORE_DEFINES_SVH

// same-cycle implication
`define VUS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vus assertion failed");

// next-cycle implication
`define VUS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vus assertion failed");

`endif

// File: hw/rtl/vus_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vus_pkg
// Types and constants shared by the utterance segmenter modules.
// ----------------------------------------------------------------------------
package vus_pkg;

    localparam int unsigned CNT_W  = 8;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_START_CONFIRM  = 3'd0;
    localparam logic [2:0] REG_SPEECH_FLUSH   = 3'd1;
    localparam logic [2:0] REG_EARLY_SILENCE  = 3'd2;
    localparam logic [2:0] REG_SILENCE_FLUSH  = 3'd3;
    localparam logic [2:0] REG_END_SILENCE    = 3'd4;

    localparam logic [CNT_W-1:0] RST_START_CONFIRM = 8'd3;
    localparam logic [CNT_W-1:0] RST_SPEECH_FLUSH  = 8'd10;
    localparam logic [CNT_W-1:0] RST_EARLY_SILENCE = 8'd3;
    localparam logic [CNT_W-1:0] RST_SILENCE_FLUSH = 8'd3;
    localparam logic [CNT_W-1:0] RST_END_SILENCE   = 8'd20;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_RESET = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] start_confirm_frames;
        logic [CNT_W-1:0] speech_flush_period;
        logic [CNT_W-1:0] early_silence_limit;
        logic [CNT_W-1:0] silence_flush_period;
        logic [CNT_W-1:0] end_silence_frames;
    } cfg_t;

    typedef struct packed {
        logic op;
        logic full_frame;
        logic speech;
        logic asr_busy;
    } item_t;

    typedef struct packed {
        logic start_utterance;
        logic append_frame;
        logic interim_request;
        logic final_request;
        logic speaking;
    } result_t;

endpackage

// File: hw/rtl/vus_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vus_cfg_regs
// APB register file holding the five segmenter thresholds.
// ----------------------------------------------------------------------------
module vus_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vus_pkg::ADDR_W-1:0]        paddr,
    input  logic [vus_pkg::DATA_W-1:0]        pwdata,
    output logic [vus_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    output vus_pkg::cfg_t                     cfg
);

    vus_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;
    logic [7:0]    rd_byte;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_confirm_frames <= vus_pkg::RST_START_CONFIRM;
            cfg_reg.speech_flush_period  <= vus_pkg::RST_SPEECH_FLUSH;
            cfg_reg.early_silence_limit  <= vus_pkg::RST_EARLY_SILENCE;
            cfg_reg.silence_flush_period <= vus_pkg::RST_SILENCE_FLUSH;
            cfg_reg.end_silence_frames   <= vus_pkg::RST_END_SILENCE;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                vus_pkg::REG_START_CONFIRM: cfg_reg.start_confirm_frames <= pwdata[7:0];
                vus_pkg::REG_SPEECH_FLUSH:  cfg_reg.speech_flush_period  <= pwdata[7:0];
                vus_pkg::REG_EARLY_SILENCE: cfg_reg.early_silence_limit  <= pwdata[7:0];
                vus_pkg::REG_SILENCE_FLUSH: cfg_reg.silence_flush_period <= pwdata[7:0];
                vus_pkg::REG_END_SILENCE:   cfg_reg.end_silence_frames   <= pwdata[7:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            vus_pkg::REG_START_CONFIRM: rd_byte = cfg_reg.start_confirm_frames;
            vus_pkg::REG_SPEECH_FLUSH:  rd_byte = cfg_reg.speech_flush_period;
            vus_pkg::REG_EARLY_SILENCE: rd_byte = cfg_reg.early_silence_limit;
            vus_pkg::REG_SILENCE_FLUSH: rd_byte = cfg_reg.silence_flush_period;
            vus_pkg::REG_END_SILENCE:   rd_byte = cfg_reg.end_silence_frames;
            default:                    rd_byte = 8'd0;
        endcase
    end

    assign prdata = {24'd0, rd_byte};

endmodule

// File: hw/rtl/vus_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vus_step
// Segmenter state registers and the per-frame decision logic.
// ----------------------------------------------------------------------------
module vus_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  vus_pkg::item_t   item,
    input  vus_pkg::cfg_t    cfg,
    output vus_pkg::result_t res
);

    logic                      in_speech_reg;
    logic [vus_pkg::CNT_W-1:0] confirm_reg;
    logic [vus_pkg::CNT_W-1:0] silence_reg;
    logic [vus_pkg::CNT_W-1:0] flush_reg;

    logic                      in_speech_next;
    logic [vus_pkg::CNT_W-1:0] confirm_next;
    logic [vus_pkg::CNT_W-1:0] silence_next;
    logic [vus_pkg::CNT_W-1:0] flush_next;

    function automatic logic [vus_pkg::CNT_W-1:0] sat_inc(input logic [vus_pkg::CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    always_comb
    begin
        in_speech_next = in_speech_reg;
        confirm_next   = confirm_reg;
        silence_next   = silence_reg;
        flush_next     = flush_reg;
        res            = '0;

        if (item.op == vus_pkg::OP_RESET)
        begin
            in_speech_next = 1'b0;
            confirm_next   = '0;
            silence_next   = '0;
            flush_next     = '0;
        end
        else if (item.full_frame)
        begin
            if (!in_speech_reg)
            begin
                if (item.speech)
                begin
                    confirm_next = sat_inc(confirm_reg);
                    if (confirm_next >= cfg.start_confirm_frames)
                    begin
                        res.start_utterance = 1'b1;
                        in_speech_next      = 1'b1;
                        silence_next        = '0;
                        flush_next          = '0;
                    end
                end
                else
                begin
                    confirm_next = '0;
                end
            end
            else
            begin
                res.append_frame = 1'b1;
                flush_next       = sat_inc(flush_reg);
                if (item.speech)
                begin
                    silence_next = '0;
                    if (flush_next >= cfg.speech_flush_period && !item.asr_busy)
                    begin
                        flush_next          = '0;
                        res.interim_request = 1'b1;
                    end
                end
                else
                begin
                    silence_next = sat_inc(silence_reg);
                    if (silence_next <= cfg.early_silence_limit &&
                        flush_next >= cfg.silence_flush_period && !item.asr_busy)
                    begin
                        flush_next          = '0;
                        res.interim_request = 1'b1;
                    end
                    // end of utterance
                    if (silence_next >= cfg.end_silence_frames)
                    begin
                        in_speech_next    = 1'b0;
                        confirm_next      = '0;
                        silence_next      = '0;
                        flush_next        = '0;
                        res.final_request = 1'b1;
                    end
                end
            end
        end

        res.speaking = in_speech_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_speech_reg <= 1'b0;
            confirm_reg   <= '0;
            silence_reg   <= '0;
            flush_reg     <= '0;
        end
        else if (en)
        begin
            in_speech_reg <= in_speech_next;
            confirm_reg   <= confirm_next;
            silence_reg   <= silence_next;
            flush_reg     <= flush_next;
        end
    end

endmodule

// File: hw/rtl/vad_utterance_segmenter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vad_utterance_segmenter_core
// Frame-by-frame utterance segmenter driven by voice-activity decisions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one frame event or a
//   segmenter reset command per transaction. Output channel (out_valid /
//   out_stall) returns exactly one result transaction per input transaction,
//   in order.
//   Path: an accepted item passes the input register, then the result
//   register, before out_valid rises; out_stall can hold it between the
//   two. Throughput: 1 transaction per cycle while out_stall is low, set by
//   the combinational decision logic between the two registers.
//   Stall: when out_stall holds a pending result, one more item is taken
//   into the input register; in_stall then rises until the result drains.
//   Reset (rst_n low): pipeline emptied, segmenter idle, counters zero,
//   thresholds back to 3 / 10 / 3 / 3 / 20.
//   Thresholds are written over APB at byte address 4*index. The user must
//   write them only while no transaction is in flight; the block has no check.
// ----------------------------------------------------------------------------
module vad_utterance_segmenter_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vus_pkg::ADDR_W-1:0] paddr,
    input  logic [vus_pkg::DATA_W-1:0] pwdata,
    output logic [vus_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic                       full_frame,
    input  logic                       speech,
    input  logic                       asr_busy,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       start_utterance,
    output logic                       append_frame,
    output logic                       interim_request,
    output logic                       final_request,
    output logic                       speaking
);

    vus_pkg::cfg_t    cfg;
    vus_pkg::item_t   item_reg;
    vus_pkg::result_t res;
    vus_pkg::result_t res_reg;

    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s1_adv;
    logic in_accept;
    logic step_en;

    vus_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vus_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step_en),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign s1_adv    = ~out_valid_reg | ~out_stall;
    assign in_stall  = s1_valid_reg & ~s1_adv;
    assign in_accept = in_valid & ~in_stall;
    assign step_en   = s1_valid_reg & s1_adv;

    assign s1_valid_next  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.op         <= op;
            item_reg.full_frame <= full_frame;
            item_reg.speech     <= speech;
            item_reg.asr_busy   <= asr_busy;
        end
        if (step_en)
        begin
            res_reg <= res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign start_utterance = res_reg.start_utterance;
    assign append_frame    = res_reg.append_frame;
    assign interim_request = res_reg.interim_request;
    assign final_request   = res_reg.final_request;
    assign speaking        = res_reg.speaking;

endmodule

// File: hw/rtl/vus_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vus_checker
// Port-level checks on the segmenter result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "vad_utterance_segmenter_core_defines.svh"

module vus_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic start_utterance,
    input logic append_frame,
    input logic interim_request,
    input logic final_request,
    input logic speaking
);

    // stalled result transaction is held
    `VUS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    // final request always leaves the segmenter idle
    `VUS_ASSERT_IMPL(a_final_idle, out_valid && final_request, !speaking)
    // a start enters speaking and does not append in the same frame
    `VUS_ASSERT_IMPL(a_start_spk, out_valid && start_utterance, speaking && !append_frame)
    // interim only on appended frames
    `VUS_ASSERT_IMPL(a_interim_app, out_valid && interim_request, append_frame)

endmodule

bind vad_utterance_segmenter_core vus_checker u_vus_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .start_utterance (start_utterance),
    .append_frame    (append_frame),
    .interim_request (interim_request),
    .final_request   (final_request),
    .speaking        (speaking)
);

// File: tb/tb_vad_utterance_segmenter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vad_utterance_segmenter_core
// Self-checking bench for the VAD utterance segmenter. A short directed
// table covers reset, short frames, start, abort and the combined
// interim/final result. Randomized utterances follow, each phase with its
// own thresholds written over APB and its own input idle and output stall
// rates. Results of typed directed rows are checked against the table,
// all others against a cycle-free model of the segmenter counters.
// ----------------------------------------------------------------------------
module tb_vad_utterance_segmenter_core;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 4;

    localparam vus_pkg::cfg_t CFG_DEFAULT  = '{8'd3, 8'd10, 8'd3, 8'd3, 8'd20};
    localparam vus_pkg::cfg_t CFG_ONES     = '{8'd1, 8'd1, 8'd1, 8'd1, 8'd1};
    localparam vus_pkg::cfg_t CFG_NO_EARLY = '{8'd1, 8'd1, 8'd0, 8'd1, 8'd1};

    localparam vus_pkg::result_t R_NONE    = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam vus_pkg::result_t R_START   = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam vus_pkg::result_t R_HOLD    = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam vus_pkg::result_t R_INT_FIN = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        vus_pkg::item_t   it;
        logic             typed;
        vus_pkg::result_t res;
        vus_pkg::cfg_t    cfg;
    } dir_row_t;

    typedef struct packed {
        vus_pkg::cfg_t cfg;
        int            send_idle;
        int            recv_stall;
        int            n_items;
    } phase_t;

    localparam int N_ROWS   = 21;
    localparam int N_PHASES = 6;

    // op, full_frame, speech, asr_busy
    localparam dir_row_t DIR_TAB [N_ROWS] = '{
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b0, 1'b0}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b0, 1'b1, 1'b1}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_RESET, 1'b1, 1'b1, 1'b1}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b0, 1'b1}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b1, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b1}, 1'b1, R_START,   '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b0, 1'b0, 1'b0}, 1'b1, R_HOLD,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b0, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_RESET, 1'b0, 1'b0, 1'b0}, 1'b1, R_NONE,    '0},
        '{ROW_CFG,  '0,                                     1'b0, R_NONE,    CFG_ONES},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b1, R_START,   '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b1}, 1'b0, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b0, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b0, 1'b0}, 1'b1, R_INT_FIN, '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b0}, 1'b1, R_START,   '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b0, 1'b1}, 1'b0, R_NONE,    '0},
        '{ROW_CFG,  '0,                                     1'b0, R_NONE,    CFG_NO_EARLY},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b1, 1'b1}, 1'b0, R_NONE,    '0},
        '{ROW_ITEM, '{vus_pkg::OP_FRAME, 1'b1, 1'b0, 1'b0}, 1'b0, R_NONE,    '0}
    };

    localparam phase_t PHASES [N_PHASES] = '{
        '{CFG_DEFAULT,                                 0,  0,  300},
        '{CFG_ONES,                                    65, 0,  300},
        '{'{8'd2, 8'd4, 8'd6, 8'd2, 8'd9},             0,  65, 300},
        '{'{8'd5, 8'd7, 8'd0, 8'd1, 8'd12},            26, 26, 300},
        '{'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255},   0,  0,  400},
        '{'{8'd1, 8'd3, 8'd2, 8'd255, 8'd30},          26, 26, 250}
    };

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         psel       = 1'b0;
    logic                         penable    = 1'b0;
    logic                         pwrite     = 1'b0;
    logic [vus_pkg::ADDR_W-1:0]   paddr      = '0;
    logic [vus_pkg::DATA_W-1:0]   pwdata     = '0;
    logic [vus_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic                         op         = vus_pkg::OP_FRAME;
    logic                         full_frame = 1'b0;
    logic                         speech     = 1'b0;
    logic                         asr_busy   = 1'b0;
    logic                         out_valid;
    logic                         out_stall  = 1'b0;
    logic                         start_utterance;
    logic                         append_frame;
    logic                         interim_request;
    logic                         final_request;
    logic                         speaking;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;

    vus_pkg::result_t exp_q [$];

    // segmenter model
    vus_pkg::cfg_t             cfg_model    = CFG_DEFAULT;
    logic                      talking      = 1'b0;
    logic [vus_pkg::CNT_W-1:0] confirm_run  = '0;
    logic [vus_pkg::CNT_W-1:0] silence_run  = '0;
    logic [vus_pkg::CNT_W-1:0] frames_since = '0;

    always #1 clk = ~clk;

    vad_utterance_segmenter_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .full_frame      (full_frame),
        .speech          (speech),
        .asr_busy        (asr_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .start_utterance (start_utterance),
        .append_frame    (append_frame),
        .interim_request (interim_request),
        .final_request   (final_request),
        .speaking        (speaking)
    );

    function automatic logic [vus_pkg::CNT_W-1:0] bump(logic [vus_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void end_segment();
        talking      = 1'b0;
        confirm_run  = '0;
        silence_run  = '0;
        frames_since = '0;
    endfunction

    function automatic vus_pkg::result_t segment_step(vus_pkg::item_t it);
        vus_pkg::result_t r;
        r = R_NONE;
        if (it.op == vus_pkg::OP_RESET)
        begin
            end_segment();
        end
        else if (it.full_frame)
        begin
            if (!talking)
            begin
                if (it.speech)
                begin
                    confirm_run = bump(confirm_run);
                    if (confirm_run >= cfg_model.start_confirm_frames)
                    begin
                        r.start_utterance = 1'b1;
                        talking           = 1'b1;
                        silence_run       = '0;
                        frames_since      = '0;
                    end
                end
                else
                begin
                    confirm_run = '0;
                end
            end
            else
            begin
                r.append_frame = 1'b1;
                frames_since   = bump(frames_since);
                if (it.speech)
                begin
                    silence_run = '0;
                    if (frames_since >= cfg_model.speech_flush_period && !it.asr_busy)
                    begin
                        frames_since      = '0;
                        r.interim_request = 1'b1;
                    end
                end
                else
                begin
                    silence_run = bump(silence_run);
                    if (silence_run <= cfg_model.early_silence_limit &&
                        frames_since >= cfg_model.silence_flush_period && !it.asr_busy)
                    begin
                        frames_since      = '0;
                        r.interim_request = 1'b1;
                    end
                    if (silence_run >= cfg_model.end_silence_frames)
                    begin
                        end_segment();
                        r.final_request = 1'b1;
                    end
                end
            end
        end
        r.speaking = talking;
        return r;
    endfunction

    function automatic vus_pkg::item_t make_frame(logic talk, bit noisy);
        vus_pkg::item_t f;
        f.op         = vus_pkg::OP_FRAME;
        f.full_frame = ($urandom_range(0, 19) != 0);
        f.speech     = talk;
        f.asr_busy   = ($urandom_range(0, 2) == 0);
        if (noisy)
        begin
            if ($urandom_range(0, 19) == 0)
                f.speech = ~talk;
            if ($urandom_range(0, 39) == 0)
                f.op = vus_pkg::OP_RESET;
        end
        return f;
    endfunction

    task automatic send_item(vus_pkg::item_t it, logic typed, vus_pkg::result_t want);
        vus_pkg::result_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= it.op;
        full_frame <= it.full_frame;
        speech     <= it.speech;
        asr_busy   <= it.asr_busy;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        r = segment_step(it);
        exp_q.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves psel high so back-to-back writes never retoggle it in one step
    task automatic apb_access(logic [2:0] idx, logic [vus_pkg::CNT_W-1:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= vus_pkg::DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
    endtask

    task automatic write_cfg(vus_pkg::cfg_t c);
        apb_access(vus_pkg::REG_START_CONFIRM, c.start_confirm_frames);
        apb_access(vus_pkg::REG_SPEECH_FLUSH,  c.speech_flush_period);
        apb_access(vus_pkg::REG_EARLY_SILENCE, c.early_silence_limit);
        apb_access(vus_pkg::REG_SILENCE_FLUSH, c.silence_flush_period);
        apb_access(vus_pkg::REG_END_SILENCE,   c.end_silence_frames);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        cfg_model  = c;
    endtask

    task automatic run_random(int n_items);
        int             left;
        int             len;
        int             span;
        int             k;
        bit             noisy;
        vus_pkg::item_t it;
        left = n_items;
        while (left > 0)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                noisy = ($urandom_range(0, 3) == 0);
                span  = (cfg_model.speech_flush_period > 20) ?
                        44 : 2 * int'(cfg_model.speech_flush_period) + 4;
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, int'(cfg_model.start_confirm_frames));
                else
                    len = int'(cfg_model.start_confirm_frames) + $urandom_range(0, span);
                for (k = 0; k < len && left > 0; k++)
                begin
                    send_item(make_frame(1'b1, noisy), 1'b0, R_NONE);
                    left--;
                end
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, int'(cfg_model.end_silence_frames));
                else
                    len = int'(cfg_model.end_silence_frames) + $urandom_range(0, 3);
                for (k = 0; k < len && left > 0; k++)
                begin
                    send_item(make_frame(1'b0, noisy), 1'b0, R_NONE);
                    left--;
                end
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len && left > 0; k++)
                begin
                    it    = vus_pkg::item_t'(4'($urandom_range(0, 15)));
                    it.op = ($urandom_range(0, 9) == 0) ? vus_pkg::OP_RESET
                                                         : vus_pkg::OP_FRAME;
                    send_item(it, 1'b0, R_NONE);
                    left--;
                end
            end
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin : result_check
        vus_pkg::result_t got;
        vus_pkg::result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got = '{start_utterance, append_frame, interim_request, final_request, speaking};
            if (exp_q.size() == 0)
            begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result transaction %b%b%b%b%b",
                             got.start_utterance, got.append_frame,
                             got.interim_request, got.final_request, got.speaking);
            end
            else
            begin
                want = exp_q.pop_front();
                if (got.start_utterance !== want.start_utterance ||
                    got.append_frame    !== want.append_frame    ||
                    got.interim_request !== want.interim_request ||
                    got.final_request   !== want.final_request   ||
                    got.speaking        !== want.speaking)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch start/append/interim/final/speaking %s %b%b%b%b%b %s %b%b%b%b%b",
                                 "exp", want.start_utterance, want.append_frame,
                                 want.interim_request, want.final_request, want.speaking,
                                 "got", got.start_utterance, got.append_frame,
                                 got.interim_request, got.final_request, got.speaking);
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) === 1'b1 || (out_valid && !out_stall) === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_cfg(DIR_TAB[i].cfg);
            end
            else
            begin
                send_item(DIR_TAB[i].it, DIR_TAB[i].typed, DIR_TAB[i].res);
            end
        end

        for (i = 0; i < N_PHASES; i++)
        begin
            wait_drained();
            write_cfg(PHASES[i].cfg);
            send_idle_pct  = PHASES[i].send_idle;
            recv_stall_pct = PHASES[i].recv_stall;
            run_random(PHASES[i].n_items);
        end

        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: vad_utterance_segmenter_core.f
+incdir+hw/rtl
hw/rtl/vus_pkg.sv
hw/rtl/vus_cfg_regs.sv
hw/rtl/vus_step.sv
hw/rtl/vad_utterance_segmenter_core.sv
hw/rtl/vus_checker.sv
tb/tb_vad_utterance_segmenter_core.sv
